// ----- sv/depth_warp_hole_fill_macros.svh -----
// assertion macros shared by the checker
`ifndef DEPTH_WARP_HOLE_FILL_MACROS_SVH
`define DEPTH_WARP_HOLE_FILL_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DWHF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DWHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent checked in the cycle after reset is seen
`define DWHF_ASSERT_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/dwhf_pkg.sv -----
package dwhf_pkg;

   localparam int DWHF_MAX_WIDTH = 2048;
   localparam int WINDOW = 64;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int COLOUR_W = 24;
   localparam int COMP_W = 8;
   localparam int COL_FIELD_W = 11;
   localparam int OFFSET_W = 6;
   localparam int SHIFT_W = 5;
   localparam int LEVELS = 8;
   localparam int LEVEL_W = $clog2(LEVELS + 1);
   localparam int DEPTH_FULL = 255;
   localparam logic [OFFSET_W-1:0] FAR_OFFSET = OFFSET_W'(25);
   localparam logic [OFFSET_W-1:0] MIN_OFFSET = OFFSET_W'(21);

   // shift per depth level, nearest level moves least
   localparam logic [SHIFT_W-1:0] SHIFT_TABLE [0:LEVELS] = '{
      5'd21, 5'd18, 5'd16, 5'd13, 5'd10, 5'd8, 5'd5, 5'd2, 5'd0
   };

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_ALIGN
   } state_type;

   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] depth;
      logic              row_last;
   } req_type;

   typedef struct packed {
      logic [COMP_W-1:0]      out_blue;
      logic [COMP_W-1:0]      out_green;
      logic [COMP_W-1:0]      out_red;
      logic [COL_FIELD_W-1:0] column;
      logic                   row_done;
      logic                   burst_last;
   } rsp_type;

   // one step of the window chain
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      logic              rotate;
      logic              clear;
   } chain_op_type;

   // level = (8*depth)/255 found by threshold compares, then table lookup
   function automatic logic [SHIFT_W-1:0] depth_shift(input logic [COMP_W-1:0] depth);
      logic [LEVEL_W-1:0]  lvl;
      logic [COMP_W+2:0]   scaled;
      scaled = {depth, 3'b000};
      lvl = '0;
      for (int k = 1; k <= LEVELS; k++) begin
         if (scaled >= (COMP_W+3)'(DEPTH_FULL * k)) begin
            lvl = LEVEL_W'(k);
         end
      end
      return SHIFT_TABLE[lvl];
   endfunction

endpackage

// ----- sv/depth_warp_hole_fill.sv -----
// channel  dir  beat                        handshake
// req      in   req_type: colour, depth     req_valid / req_ready
// rsp      out  rsp_type: colour, column    rsp_valid / rsp_ready
// csr      in   max_offset, 6 bits          csr_valid / csr_ready
//
// a pixel that is not the row end gives at most one beat
// the row end pixel starts a flush of one column a cycle while rsp is not stalled
// (at most 64) through the head of the 64-cell window chain, then the chain is
// turned back to slot 0
// req_ready is low through flush and realignment and while rsp is stalled
// reset (synchronous) empties the window, clears counters, max_offset to 25
module depth_warp_hole_fill
   import dwhf_pkg::*;
#(
   parameter int MAX_WIDTH = DWHF_MAX_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [OFFSET_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EXT_W = COL_W + 1;

   state_type           state_ff, state_in;
   logic [OFFSET_W-1:0] max_offset_ff, max_offset_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [EXT_W-1:0]    emit_col_ff, emit_col_in;
   logic [COL_W-1:0]    j_end_ff, j_end_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [COLOUR_W-1:0] prev_ff, prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                slot_free;
   logic                req_fire;
   logic [OFFSET_W-1:0] off;
   logic [EXT_W-1:0]    off_ext;
   logic [EXT_W-1:0]    wr_sum;
   logic [EXT_W-1:0]    wr_col;
   logic                wr_ok;
   logic                row_end;
   logic                run_emit;
   logic                flush_go;
   logic [COLOUR_W-1:0] colour_in;
   logic [COLOUR_W-1:0] head_val;
   logic [SLOT_W-1:0]   head_slot;
   logic [COLOUR_W-1:0] emit_val;
   chain_op_type        op;
   logic                emit;
   logic                emit_row_done;
   logic                emit_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && slot_free;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign off = (max_offset_ff < MIN_OFFSET) ? MIN_OFFSET : max_offset_ff;
   assign off_ext = EXT_W'(off);
   assign colour_in = {req_data.red, req_data.green, req_data.blue};
   assign wr_sum = EXT_W'(in_col_ff) + EXT_W'(depth_shift(req_data.depth));
   assign wr_ok = wr_sum >= off_ext;
   assign wr_col = wr_sum - off_ext;
   assign row_end = req_data.row_last || (in_col_ff == COL_W'(MAX_WIDTH - 1));
   // a column is final once no later pixel of the row can land on it
   assign run_emit = !row_end && (emit_col_ff + off_ext <= EXT_W'(in_col_ff));
   assign flush_go = (emit_col_ff <= EXT_W'(j_end_ff)) && (n_ff < CNT_W'(WINDOW));

   // holes take the last colour sent, except at the left edge
   assign emit_val = (head_val == '0 && emit_col_ff != '0) ? prev_ff : head_val;

   dwhf_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .wr_data   (colour_in),
      .head_val  (head_val),
      .head_slot (head_slot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_fire && row_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!flush_go) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (head_slot == '0) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      op = '0;
      op.clear = 1'b1;
      emit = 1'b0;
      emit_row_done = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         ST_RUN: begin
            op.wr_en = req_fire && wr_ok;
            op.wr_slot = wr_col[SLOT_W-1:0];
            op.rotate = req_fire && run_emit;
            emit = req_fire && run_emit;
            emit_last = 1'b1;
         end
         ST_FLUSH: begin
            op.rotate = flush_go && slot_free;
            emit = flush_go && slot_free;
            emit_row_done = emit_col_ff == EXT_W'(j_end_ff);
            emit_last = emit_row_done || (n_ff == CNT_W'(WINDOW - 1));
         end
         ST_ALIGN: begin
            op.rotate = head_slot != '0;
            op.clear = 1'b0;
         end
         default: begin
            op.clear = 1'b1;
         end
      endcase
   end

   always_comb begin
      max_offset_in = csr_valid ? csr_data : max_offset_ff;

      in_col_in = in_col_ff;
      j_end_in = j_end_ff;
      if (req_fire) begin
         in_col_in = row_end ? '0 : in_col_ff + COL_W'(1);
         if (row_end) begin
            j_end_in = in_col_ff;
         end
      end

      emit_col_in = emit_col_ff;
      n_in = n_ff;
      if (emit) begin
         emit_col_in = emit_col_ff + EXT_W'(1);
         if (state_ff == ST_FLUSH) begin
            n_in = n_ff + CNT_W'(1);
         end
      end
      if (state_ff == ST_FLUSH && !flush_go) begin
         emit_col_in = '0;
         n_in = '0;
      end

      prev_in = emit ? emit_val : prev_ff;

      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_blue = emit_val[COMP_W-1:0];
         rsp_data_in.out_green = emit_val[2*COMP_W-1:COMP_W];
         rsp_data_in.out_red = emit_val[3*COMP_W-1:2*COMP_W];
         rsp_data_in.column = COL_FIELD_W'(emit_col_ff);
         rsp_data_in.row_done = emit_row_done;
         rsp_data_in.burst_last = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         max_offset_ff <= FAR_OFFSET;
         in_col_ff <= '0;
         emit_col_ff <= '0;
         j_end_ff <= '0;
         n_ff <= '0;
         prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_offset_ff <= max_offset_in;
         in_col_ff <= in_col_in;
         emit_col_ff <= emit_col_in;
         j_end_ff <= j_end_in;
         n_ff <= n_in;
         prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- sv/dwhf_cell.sv -----
module dwhf_cell
   import dwhf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_hit,
   input  logic [COLOUR_W-1:0] wr_data,
   input  logic                rotate,
   input  logic [COLOUR_W-1:0] nbr_val,
   output logic [COLOUR_W-1:0] eff_val
);

   logic [COLOUR_W-1:0] val_ff;
   logic [COLOUR_W-1:0] val_in;

   // a write this cycle is visible to the neighbour and to the reader at once
   assign eff_val = wr_hit ? wr_data : val_ff;

   always_comb begin
      val_in = rotate ? nbr_val : eff_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

endmodule

// ----- sv/dwhf_chain.sv -----
module dwhf_chain
   import dwhf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  chain_op_type        op,
   input  logic [COLOUR_W-1:0] wr_data,
   output logic [COLOUR_W-1:0] head_val,
   output logic [SLOT_W-1:0]   head_slot
);

   logic [SLOT_W-1:0]   head_ff;
   logic [SLOT_W-1:0]   head_in;
   logic [SLOT_W-1:0]   wr_idx;
   logic [COLOUR_W-1:0] eff [WINDOW];
   logic [COLOUR_W-1:0] nbr [WINDOW];

   // cell k holds slot head+k, so the target cell is the slot less the head
   assign wr_idx = op.wr_slot - head_ff;

   always_comb begin
      head_in = op.rotate ? head_ff + SLOT_W'(1) : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   genvar k;
   generate
      for (k = 0; k < WINDOW; k++) begin : g_cell
         if (k == WINDOW - 1) begin : g_tail
            // the slot leaving the head wraps to the tail, emptied once emitted
            assign nbr[k] = op.clear ? '0 : eff[0];
         end else begin : g_body
            assign nbr[k] = eff[k+1];
         end
         dwhf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr_hit  (op.wr_en && (wr_idx == SLOT_W'(k))),
            .wr_data (wr_data),
            .rotate  (op.rotate),
            .nbr_val (nbr[k]),
            .eff_val (eff[k])
         );
      end
   endgenerate

   assign head_val = eff[0];
   assign head_slot = head_ff;

endmodule

// ----- sv/dwhf_checker.sv -----
`include "depth_warp_hole_fill_macros.svh"

module dwhf_checker
   import dwhf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input req_type             req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsp_type             rsp_data
);

   // a stalled beat holds
   `DWHF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // the row end beat starts a flush, so no pixel is taken right after it
   `DWHF_ASSERT_NEXT(a_row_end_stall, clock, reset, req_valid && req_ready && req_data.row_last, !req_ready, "pixel taken during row flush")

   // the last column of a row always closes its burst
   `DWHF_ASSERT_SAME(a_row_done_last, clock, reset, rsp_valid && rsp_data.row_done, rsp_data.burst_last, "row_done without burst_last")

   `DWHF_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind depth_warp_hole_fill dwhf_checker u_dwhf_checker (.*);
